// ===== rtl/bitmap_contiguous_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator checker.
// Uses clk_i and rst_ni from the enclosing scope; no other dependencies.
`ifndef BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BCBA_ASSERT_IMP(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("bcba check failed");

// next-cycle implication
`define BCBA_ASSERT_NXT(name, a, b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("bcba check failed");

`endif

// ===== rtl/bcba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// No dependencies.
package bcba_pkg;

  localparam int unsigned NUM_BLOCKS = 4096;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_ROWS   = NUM_BLOCKS / WORD_W;
  localparam int unsigned ROW_W      = $clog2(NUM_ROWS);
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned BLK_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W      = BLK_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);
  localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(NUM_ROWS - 1);

  localparam logic [1:0] MODE_FORMAT = 2'd0;
  localparam logic [1:0] MODE_ALLOC  = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] block_count;
    logic [BLK_W-1:0] start_block;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] found_start;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] hit_bit;
    logic [CNT_W-1:0] run_out;
  } scan_t;

endpackage

// ===== rtl/bitmap_contiguous_block_allocator.sv =====
// Top level of the first-fit contiguous block allocator over a used-block bitmap.
// Depends on bcba_pkg, bcba_ram and bcba_word_scan.
//
//   channel   ports                          handshake
//   command   start, busy, cmd_i             taken when start && !busy
//   result    done_o, res_o                  one-cycle strobe, no backpressure
//   config    cfg_we_i, cfg_idx_i, cfg_data_i  written when cfg_we_i
//
// The map is 128 words of 32 bits in one RAM; one word is read per cycle.
// Format writes every row; Allocate scans for a first fit, then marks its range.
// Free clears its range. No space ends at the last row. Rejects keep busy low.
// After reset the map reads as all used; per-row valid bits stand in for it.
// Results cannot be stalled; busy stays high until the result strobe.
module bitmap_contiguous_block_allocator import bcba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 cmd_i,
  output logic                 done_o,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FMT  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FILL = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  total_q, reserved_q;
  logic [CNT_W-1:0]  lim, res_eff;
  logic [CNT_W-1:0]  need_q, need_d, lo_q, lo_d, hi_q, hi_d, run_q, run_d;
  logic              set_q, set_d;
  logic [BLK_W-1:0]  found_q, found_d;
  logic [ROW_W-1:0]  iss_row_q, iss_row_d, pend_row_q, pend_row_d;
  logic              iss_done_q, iss_done_d, pend_q, pend_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;
  logic [NUM_ROWS-1:0] vld_q;
  logic              vld_set;
  logic [ROW_W-1:0]  vld_row;
  logic              rd_vld_q;
  logic              ram_we, ram_re;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, word;
  logic [CNT_W:0]    free_hi;
  logic [CNT_W-1:0]  hi_m1, hit_idx;
  logic [ROW_W-1:0]  last_row;
  scan_t             scan;

  function automatic logic [WORD_W-1:0] fmt_word(logic [ROW_W-1:0] row,
                                                 logic [CNT_W-1:0] rsv,
                                                 logic [CNT_W-1:0] top);
    logic [WORD_W-1:0] w;
    logic [CNT_W-1:0]  idx;
    for (int b = 0; b < WORD_W; b++) begin
      idx  = CNT_W'({row, BIT_W'(b)});
      w[b] = (idx < rsv) || (idx >= top);
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] range_mask(logic [ROW_W-1:0] row,
                                                   logic [CNT_W-1:0] lo,
                                                   logic [CNT_W-1:0] hi);
    logic [WORD_W-1:0] m;
    logic [CNT_W-1:0]  idx;
    for (int b = 0; b < WORD_W; b++) begin
      idx  = CNT_W'({row, BIT_W'(b)});
      m[b] = (idx >= lo) && (idx < hi);
    end
    return m;
  endfunction

  assign lim      = (total_q > NUM_BLOCKS_C) ? NUM_BLOCKS_C : total_q;
  assign res_eff  = (reserved_q > NUM_BLOCKS_C) ? NUM_BLOCKS_C : reserved_q;
  assign free_hi  = (CNT_W+1)'(cmd_i.start_block) + (CNT_W+1)'(cmd_i.block_count);
  assign hi_m1    = hi_q - CNT_W'(1);
  assign last_row = hi_m1[BLK_W-1:BIT_W];
  assign word     = rd_vld_q ? ram_rdata : '1;
  assign hit_idx  = CNT_W'({pend_row_q, scan.hit_bit});

  bcba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bcba_word_scan u_scan (
    .word_i(word),
    .row_i (pend_row_q),
    .run_i (run_q),
    .need_i(need_q),
    .lim_i (lim),
    .res_o (scan)
  );

  always_comb begin
    state_d    = state_q;
    need_d     = need_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    run_d      = run_q;
    set_d      = set_q;
    found_d    = found_q;
    iss_row_d  = iss_row_q;
    iss_done_d = iss_done_q;
    pend_d     = 1'b0;
    pend_row_d = iss_row_q;
    done_d     = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = pend_row_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = iss_row_q;
    vld_set    = 1'b0;
    vld_row    = pend_row_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          iss_done_d = 1'b0;
          case (cmd_i.mode)
            MODE_FORMAT: begin
              state_d   = ST_FMT;
              iss_row_d = '0;
            end
            MODE_ALLOC: begin
              if (cmd_i.block_count != '0) begin
                state_d   = ST_SCAN;
                iss_row_d = '0;
                run_d     = '0;
                need_d    = cmd_i.block_count;
              end else begin
                res_d  = '{status: STATUS_BAD, found_start: '0};
                done_d = 1'b1;
              end
            end
            MODE_FREE: begin
              if (cmd_i.block_count != '0 && free_hi <= {1'b0, lim}) begin
                state_d   = ST_FILL;
                lo_d      = CNT_W'(cmd_i.start_block);
                hi_d      = free_hi[CNT_W-1:0];
                set_d     = 1'b0;
                found_d   = '0;
                iss_row_d = cmd_i.start_block[BLK_W-1:BIT_W];
              end else begin
                res_d  = '{status: STATUS_BAD, found_start: '0};
                done_d = 1'b1;
              end
            end
            default: begin
              res_d  = '{status: STATUS_BAD, found_start: '0};
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = iss_row_q;
        ram_wdata = fmt_word(iss_row_q, res_eff, lim);
        vld_set   = 1'b1;
        vld_row   = iss_row_q;
        iss_row_d = iss_row_q + ROW_W'(1);
        if (iss_row_q == ROW_LAST) begin
          state_d = ST_IDLE;
          res_d   = '{status: STATUS_OK, found_start: '0};
          done_d  = 1'b1;
        end
      end

      ST_SCAN: begin
        if (!iss_done_q) begin
          ram_re    = 1'b1;
          iss_row_d = iss_row_q + ROW_W'(1);
          pend_d    = 1'b1;
          if (iss_row_q == ROW_LAST) begin
            iss_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          if (scan.hit) begin
            lo_d       = hit_idx + CNT_W'(1) - need_q;
            hi_d       = hit_idx + CNT_W'(1);
            set_d      = 1'b1;
            found_d    = lo_d[BLK_W-1:0];
            iss_row_d  = lo_d[BLK_W-1:BIT_W];
            iss_done_d = 1'b0;
            pend_d     = 1'b0;
            state_d    = ST_FILL;
          end else begin
            run_d = scan.run_out;
            if (pend_row_q == ROW_LAST) begin
              state_d = ST_IDLE;
              res_d   = '{status: STATUS_NO_SPACE, found_start: '0};
              done_d  = 1'b1;
            end
          end
        end
      end

      ST_FILL: begin
        if (!iss_done_q) begin
          ram_re    = 1'b1;
          iss_row_d = iss_row_q + ROW_W'(1);
          pend_d    = 1'b1;
          if (iss_row_q == last_row) begin
            iss_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          ram_we  = 1'b1;
          vld_set = 1'b1;
          if (set_q) begin
            ram_wdata = word | range_mask(pend_row_q, lo_q, hi_q);
          end else begin
            ram_wdata = word & ~range_mask(pend_row_q, lo_q, hi_q);
          end
          if (pend_row_q == last_row) begin
            state_d = ST_IDLE;
            res_d   = '{status: STATUS_OK, found_start: found_q};
            done_d  = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= NUM_BLOCKS_C;
      reserved_q <= CNT_W'(34);
      iss_done_q <= 1'b0;
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
      vld_q      <= '0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
      if (vld_set) begin
        vld_q[vld_row] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL:    total_q    <= cfg_data_i;
          CFG_RESERVED: reserved_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    run_q      <= run_d;
    set_q      <= set_d;
    found_q    <= found_d;
    iss_row_q  <= iss_row_d;
    pend_row_q <= pend_row_d;
    res_q      <= res_d;
    if (ram_re) begin
      rd_vld_q <= vld_q[ram_raddr];
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/bcba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bcba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bcba_word_scan.sv =====
// First-fit search step over one 32-bit word of the used map.
// Depends on bcba_pkg.
module bcba_word_scan import bcba_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [CNT_W-1:0]  run_i,
  input  logic [CNT_W-1:0]  need_i,
  input  logic [CNT_W-1:0]  lim_i,
  output scan_t             res_o
);

  logic [WORD_W-1:0] free;

  always_comb begin
    logic [CNT_W-1:0] idx;
    for (int b = 0; b < WORD_W; b++) begin
      idx     = CNT_W'({row_i, BIT_W'(b)});
      free[b] = !word_i[b] && (idx < lim_i);
    end
  end

  always_comb begin
    logic [BIT_W:0]   p;
    logic [CNT_W-1:0] len;
    res_o = '0;
    for (int b = 0; b < WORD_W; b++) begin
      p = '0;
      for (int j = 0; j <= b; j++) begin
        if (!free[j]) begin
          p = (BIT_W+1)'(j + 1);
        end
      end
      if (p == '0) begin
        len = run_i + CNT_W'(b + 1);
      end else begin
        len = CNT_W'(b + 1) - CNT_W'(p);
      end
      if (!res_o.hit && free[b] && (len >= need_i)) begin
        res_o.hit     = 1'b1;
        res_o.hit_bit = BIT_W'(b);
      end
      res_o.run_out = len;
    end
  end

endmodule

// ===== rtl/bcba_checker.sv =====
// Port-level checks of the bitmap block allocator, bound to the top level.
// Depends on bcba_pkg and bitmap_contiguous_block_allocator_macros.svh.
`include "bitmap_contiguous_block_allocator_macros.svh"

module bcba_checker import bcba_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  `BCBA_ASSERT_NXT(a_accept_answers, start && !busy, busy || done_o)
  `BCBA_ASSERT_IMP(a_done_when_idle, done_o, !busy)
  `BCBA_ASSERT_IMP(a_busy_ends_in_word, $fell(busy), done_o)
  `BCBA_ASSERT_IMP(a_start_zero_unless_ok, done_o && res_o.status != STATUS_OK,
                   res_o.found_start == '0)
  `BCBA_ASSERT_IMP(a_status_known, done_o,
                   res_o.status == STATUS_OK || res_o.status == STATUS_NO_SPACE ||
                   res_o.status == STATUS_BAD)

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_bcba_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);
